// ===== hw/rtl/ssrs_pkg.sv =====
// ----------------------------------------------------------------------------
// steady-state replacement select package
// shared widths, codes, payload structs and controller/datapath interface
// ----------------------------------------------------------------------------
package ssrs_pkg;

	// default population table depth
	localparam int POP_SIZE_DEFAULT = 64;

	// field widths
	localparam int SLOT_W    = 6;
	localparam int FIT_W     = 32;
	localparam int KEY_W     = FIT_W + 2;
	localparam int CNT_W     = 7;
	localparam int SLOT_SPAN = 64;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_OFFER = 1'b1;

	// replacement policies
	typedef enum logic [1:0] {
		POLICY_WORST          = 2'd0,
		POLICY_SIMILAR        = 2'd1,
		POLICY_WORST_PARENT   = 2'd2,
		POLICY_SIMILAR_PARENT = 2'd3
	} policy_t;

	// register indexes
	typedef enum logic {
		REG_POLICY    = 1'b0,
		REG_POP_COUNT = 1'b1
	} reg_idx_t;

	// compare operation applied to a table read
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_FIRST = 2'd1,
		OP_LT    = 2'd2,
		OP_LE    = 2'd3
	} dp_op_t;

	// table read address source
	typedef enum logic [1:0] {
		ASEL_SLOT = 2'd0,
		ASEL_PA   = 2'd1,
		ASEL_PB   = 2'd2,
		ASEL_SCAN = 2'd3
	} addr_sel_t;

	// request payload
	typedef struct packed {
		logic                    req_type;
		logic [SLOT_W-1:0]       slot_index;
		logic signed [FIT_W-1:0] fitness_value;
		logic [SLOT_W-1:0]       parent_a_slot;
		logic [SLOT_W-1:0]       parent_b_slot;
	} item_t;

	// result payload
	typedef struct packed {
		logic [SLOT_W-1:0]       chosen_slot;
		logic signed [FIT_W-1:0] evicted_fitness;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic             load_item;
		logic             rd_en;
		addr_sel_t        addr_sel;
		logic [CNT_W-1:0] scan_addr;
		dp_op_t           op;
		logic             commit;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic pipe_busy;
	} dp_status_t;

endpackage

// ===== hw/rtl/ssrs_ram.sv =====
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ssrs_ram #(
	parameter int Width = ssrs_pkg::FIT_W,
	parameter int Depth = ssrs_pkg::POP_SIZE_DEFAULT,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/ssrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// replacement select controller
// sequences table reads per request, waits for the compare pipe, commits
// ----------------------------------------------------------------------------
module ssrs_ctrl #(
	parameter int POP_SIZE = ssrs_pkg::POP_SIZE_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  ssrs_pkg::policy_t             policy,
	input  logic [ssrs_pkg::CNT_W-1:0]    pop_count,
	output ssrs_pkg::dp_cmd_t             cmd,
	input  ssrs_pkg::dp_status_t          status
);

	localparam int CAP = (POP_SIZE < ssrs_pkg::SLOT_SPAN) ? POP_SIZE : ssrs_pkg::SLOT_SPAN;
	localparam logic [ssrs_pkg::CNT_W-1:0] CAP_CNT  = ssrs_pkg::CNT_W'(CAP);
	localparam logic [ssrs_pkg::CNT_W-1:0] LAST_MAX = ssrs_pkg::CNT_W'(CAP - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_PARENT_A,
		S_PARENT_B,
		S_FINISH
	} state_t;

	state_t                         state_q;
	logic [ssrs_pkg::CNT_W-1:0]     scan_cnt_q;
	logic                           out_valid_q;
	logic [ssrs_pkg::CNT_W-1:0]     scan_last;
	logic                           accept;
	logic                           commit;

	// last slot of the whole-population scan, count clamped to the table
	always_comb begin
		if (pop_count == '0) begin
			scan_last = '0;
		end else if (pop_count > CAP_CNT) begin
			scan_last = LAST_MAX;
		end else begin
			scan_last = pop_count - ssrs_pkg::CNT_W'(1);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign commit    = (state_q == S_FINISH) && !status.pipe_busy &&
		(!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// state and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					scan_cnt_q <= '0;
					if (accept) begin
						if (req_type == ssrs_pkg::REQ_LOAD) begin
							state_q <= S_LOAD;
						end else if (policy == ssrs_pkg::POLICY_WORST ||
							policy == ssrs_pkg::POLICY_SIMILAR) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_PARENT_A;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_FINISH;
				end
				S_SCAN: begin
					scan_cnt_q <= scan_cnt_q + ssrs_pkg::CNT_W'(1);
					if (scan_cnt_q == scan_last) begin
						state_q <= S_FINISH;
					end
				end
				S_PARENT_A: begin
					state_q <= S_PARENT_B;
				end
				S_PARENT_B: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.load_item = accept;
		cmd.commit    = commit;
		cmd.scan_addr = scan_cnt_q;
		cmd.addr_sel  = ssrs_pkg::ASEL_SLOT;
		cmd.op        = ssrs_pkg::OP_NONE;
		unique case (state_q)
			S_LOAD: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = ssrs_pkg::ASEL_SLOT;
				cmd.op       = ssrs_pkg::OP_FIRST;
			end
			S_SCAN: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = ssrs_pkg::ASEL_SCAN;
				if (scan_cnt_q == '0) begin
					cmd.op = ssrs_pkg::OP_FIRST;
				end else if (policy == ssrs_pkg::POLICY_WORST) begin
					cmd.op = ssrs_pkg::OP_LT;
				end else begin
					cmd.op = ssrs_pkg::OP_LE;
				end
			end
			S_PARENT_A: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = ssrs_pkg::ASEL_PA;
				cmd.op       = ssrs_pkg::OP_FIRST;
			end
			S_PARENT_B: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = ssrs_pkg::ASEL_PB;
				cmd.op       = ssrs_pkg::OP_LT;
			end
			default: begin
				cmd.rd_en = 1'b0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ssrs_dp.sv =====
// ----------------------------------------------------------------------------
// replacement select datapath
// fitness table, distance/key stage, running best and result register
// ----------------------------------------------------------------------------
module ssrs_dp #(
	parameter int POP_SIZE = ssrs_pkg::POP_SIZE_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssrs_pkg::item_t      in_item,
	input  ssrs_pkg::policy_t    policy,
	input  ssrs_pkg::dp_cmd_t    cmd,
	output ssrs_pkg::dp_status_t status,
	output ssrs_pkg::result_t    out_item
);

	localparam int AW    = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
	localparam int KEY_W = ssrs_pkg::KEY_W;
	localparam int FIT_W = ssrs_pkg::FIT_W;

	ssrs_pkg::item_t          item_q;
	logic [AW-1:0]            wrap_lut [ssrs_pkg::SLOT_SPAN];
	logic [AW-1:0]            rd_addr;
	logic [FIT_W-1:0]         rdata;

	ssrs_pkg::dp_op_t         op_s1;
	logic [AW-1:0]            idx_s1;
	ssrs_pkg::dp_op_t         op_s2;
	logic [AW-1:0]            idx_s2;
	logic signed [KEY_W-1:0]  key_s2;
	logic [FIT_W-1:0]         fit_s2;

	logic signed [KEY_W-1:0]  fit_ext;
	logic signed [KEY_W-1:0]  child_ext;
	logic signed [KEY_W-1:0]  diff_p;
	logic signed [KEY_W-1:0]  diff_n;
	logic signed [KEY_W-1:0]  key;

	logic signed [KEY_W-1:0]  best_key_q;
	logic [FIT_W-1:0]         best_fit_q;
	logic [AW-1:0]            best_idx_q;
	ssrs_pkg::result_t        out_q;

	// request hold
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_item;
		end
	end

	// slot number reduced to the table depth
	for (genvar g = 0; g < ssrs_pkg::SLOT_SPAN; g++) begin : g_wrap
		assign wrap_lut[g] = AW'(g % POP_SIZE);
	end

	// read address select
	always_comb begin
		unique case (cmd.addr_sel)
			ssrs_pkg::ASEL_SLOT: rd_addr = wrap_lut[item_q.slot_index];
			ssrs_pkg::ASEL_PA:   rd_addr = wrap_lut[item_q.parent_a_slot];
			ssrs_pkg::ASEL_PB:   rd_addr = wrap_lut[item_q.parent_b_slot];
			ssrs_pkg::ASEL_SCAN: rd_addr = AW'(cmd.scan_addr);
			default:             rd_addr = '0;
		endcase
	end

	// fitness table
	ssrs_ram #(
		.Width(FIT_W),
		.Depth(POP_SIZE)
	) u_table (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(best_idx_q),
		.wdata(item_q.fitness_value),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// read tag follows the ram latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= ssrs_pkg::OP_NONE;
			op_s2 <= ssrs_pkg::OP_NONE;
		end else begin
			op_s1 <= cmd.rd_en ? cmd.op : ssrs_pkg::OP_NONE;
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
	end

	// key: fitness for worst policies, absolute distance for similar ones
	assign fit_ext   = KEY_W'(signed'(rdata));
	assign child_ext = KEY_W'(item_q.fitness_value);
	assign diff_p    = fit_ext - child_ext;
	assign diff_n    = child_ext - fit_ext;

	always_comb begin
		if (policy == ssrs_pkg::POLICY_SIMILAR || policy == ssrs_pkg::POLICY_SIMILAR_PARENT) begin
			key = diff_p[KEY_W-1] ? diff_n : diff_p;
		end else begin
			key = fit_ext;
		end
	end

	always_ff @(posedge clk) begin
		key_s2 <= key;
		fit_s2 <= rdata;
		idx_s2 <= idx_s1;
	end

	// running best
	always_ff @(posedge clk) begin
		unique case (op_s2)
			ssrs_pkg::OP_FIRST: begin
				best_key_q <= key_s2;
				best_fit_q <= fit_s2;
				best_idx_q <= idx_s2;
			end
			ssrs_pkg::OP_LT: begin
				if (key_s2 < best_key_q) begin
					best_key_q <= key_s2;
					best_fit_q <= fit_s2;
					best_idx_q <= idx_s2;
				end
			end
			ssrs_pkg::OP_LE: begin
				if (key_s2 <= best_key_q) begin
					best_key_q <= key_s2;
					best_fit_q <= fit_s2;
					best_idx_q <= idx_s2;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.chosen_slot     <= ssrs_pkg::SLOT_W'(best_idx_q);
			out_q.evicted_fitness <= best_fit_q;
		end
	end

	assign out_item         = out_q;
	assign status.pipe_busy = (op_s1 != ssrs_pkg::OP_NONE) || (op_s2 != ssrs_pkg::OP_NONE);

endmodule

// ===== hw/rtl/steady_state_replacement_select.sv =====
// load and parent-policy requests commit once their slot reads have left the compare pipe
// a whole-population scan reads one slot per cycle, then commits once the pipe drains
// one request at a time: a new request is taken only after the last one has committed
// the next request is taken while a result waits in the output register
// reset clears policy to worst and population count to 64; table contents stay undefined
// ----------------------------------------------------------------------------
// steady-state replacement select
// population fitness table with policy-driven victim selection and apb config
// ----------------------------------------------------------------------------
module steady_state_replacement_select #(
	parameter int POP_SIZE = ssrs_pkg::POP_SIZE_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ssrs_pkg::item_t               in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ssrs_pkg::result_t             out_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssrs_pkg::ADDR_W-1:0]   paddr,
	input  logic [ssrs_pkg::DATA_W-1:0]   pwdata,
	output logic [ssrs_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	ssrs_pkg::policy_t              policy_q;
	logic [ssrs_pkg::CNT_W-1:0]     pop_count_q;
	ssrs_pkg::reg_idx_t             reg_idx;
	ssrs_pkg::dp_cmd_t              cmd;
	ssrs_pkg::dp_status_t           status;

	assign reg_idx = ssrs_pkg::reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= ssrs_pkg::POLICY_WORST;
			pop_count_q <= ssrs_pkg::CNT_W'(64);
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				ssrs_pkg::REG_POLICY:    policy_q    <= ssrs_pkg::policy_t'(pwdata[1:0]);
				ssrs_pkg::REG_POP_COUNT: pop_count_q <= pwdata[ssrs_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			ssrs_pkg::REG_POLICY:    prdata = ssrs_pkg::DATA_W'(policy_q);
			ssrs_pkg::REG_POP_COUNT: prdata = ssrs_pkg::DATA_W'(pop_count_q);
			default:                 prdata = '0;
		endcase
	end

	ssrs_ctrl #(
		.POP_SIZE(POP_SIZE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (in_item.req_type),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.policy   (policy_q),
		.pop_count(pop_count_q),
		.cmd      (cmd),
		.status   (status)
	);

	ssrs_dp #(
		.POP_SIZE(POP_SIZE)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.policy  (policy_q),
		.cmd     (cmd),
		.status  (status),
		.out_item(out_item)
	);

endmodule

// ===== hw/rtl/ssrs_checker.sv =====
// ----------------------------------------------------------------------------
// replacement select checker
// port-level properties of the request and result channels
// ----------------------------------------------------------------------------
module ssrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input ssrs_pkg::result_t             out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// one request at a time: busy after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// no result in the cycle straight after acceptance
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	// a new result means the block is back to idle
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while still busy");

endmodule

bind steady_state_replacement_select ssrs_checker u_checker (.*);
